### rtl/core/rbh_pkg.sv
package rbh_pkg;

    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 32;
    localparam int WIDTH_W   = 6;
    localparam int QBUF_W    = 40;
    localparam int NRES_W    = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 6;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_BIT_WIDTH       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_PREFIXED = 1'b1;

    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_TRUNC_VARINT = 2'd1,
        ERR_TRUNC_RUN    = 2'd2,
        ERR_VARINT_LONG  = 2'd3
    } err_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_beat_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] repeat_count;
        logic               last_of_item;
        err_t               error_code;
    } out_beat_t;

    // one queued byte: its values come from the low end of word, width bits each
    typedef struct packed {
        logic [QBUF_W-1:0]  word;
        logic [COUNT_W-1:0] count;
        logic [NRES_W-1:0]  n_results;
        logic [WIDTH_W-1:0] width;
        err_t               err;
    } q_entry_t;

    function automatic logic [VALUE_W-1:0] width_mask(input logic [WIDTH_W-1:0] w);
        logic [VALUE_W-1:0] m;
        if (w >= WIDTH_W'(VALUE_W)) begin
            m = '1;
        end else begin
            m = (VALUE_W'(1) << w) - VALUE_W'(1);
        end
        return m;
    endfunction

endpackage

### rtl/core/rbh_queue.sv
module rbh_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  rbh_pkg::q_entry_t wdata,
    output logic              full,
    output logic              rd_valid,
    output rbh_pkg::q_entry_t rdata,
    input  logic              pop
);
    import rbh_pkg::*;

    q_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;

    assign full     = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rdata    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + (QPTR_W+1)'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### rtl/core/rbh_front.sv
module rbh_front #(
    parameter int MAX_BIT_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  rbh_pkg::in_beat_t                 s_data,
    input  logic                              cfg_we,
    input  logic [rbh_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [rbh_pkg::CFG_DAT_W-1:0]     cfg_wdata,
    output logic                              q_push,
    output rbh_pkg::q_entry_t                 q_wdata,
    input  logic                              q_full
);
    import rbh_pkg::*;

    localparam int BUF_W = MAX_BIT_WIDTH + 8;
    localparam int HDR_W = 35;
    localparam int PVL_W = HDR_W + 2;
    localparam int KW_W  = 9;

    typedef enum logic [5:0] {
        PH_START  = 6'b000001,
        PH_PREFIX = 6'b000010,
        PH_HEADER = 6'b000100,
        PH_RLE    = 6'b001000,
        PH_PACKED = 6'b010000,
        PH_DRAIN  = 6'b100000
    } phase_t;

    logic [WIDTH_W-1:0] bit_width_reg;
    logic               len_pref_reg;

    phase_t             phase_reg, phase_next, ph;
    logic [31:0]        bytes_rem_reg, bytes_rem_next;
    logic [1:0]         prefix_idx_reg, prefix_idx_next;
    logic [HDR_W-1:0]   hdr_acc_reg, hdr_acc_next;
    logic [2:0]         shift_cnt_reg, shift_cnt_next;
    logic [COUNT_W-1:0] run_count_reg, run_count_next;
    logic [31:0]        val_acc_reg, val_acc_next;
    logic [1:0]         val_idx_reg, val_idx_next;
    logic [BUF_W-1:0]   bit_buf_reg, bit_buf_next;
    logic [5:0]         bits_reg, bits_next;
    logic [PVL_W-1:0]   pvl_reg, pvl_next;
    logic               counted_reg, counted_next;
    logic [WIDTH_W-1:0] gw_reg, gw_next;

    logic               accept;
    logic [7:0]         b;
    logic [WIDTH_W-1:0] eff_w;
    logic [5:0]         hdr_shamt;
    logic [HDR_W-1:0]   hdr_acc_new;
    logic [HDR_W-2:0]   hdr_count;
    logic [31:0]        val_acc_new;
    logic [2:0]         rle_nbytes;
    logic               rle_done;
    logic [5:0]         bits_sum;
    logic [BUF_W-1:0]   buf_new;
    logic [KW_W-1:0]    prod [9];
    logic [NRES_W-1:0]  k_fit, k_cap, k;
    logic [KW_W-1:0]    kw;
    logic [BUF_W-1:0]   buf_shift;
    logic [5:0]         bits_rem;
    logic [PVL_W-1:0]   pvl_rem;

    logic               data_seen;
    err_t               err;
    q_entry_t           ent;

    assign accept  = s_valid && s_ready;
    assign s_ready = !q_full;
    assign b       = s_data.data_byte;

    always_comb begin
        if (bit_width_reg == '0) begin
            eff_w = WIDTH_W'(1);
        end else if (bit_width_reg > WIDTH_W'(MAX_BIT_WIDTH)) begin
            eff_w = WIDTH_W'(MAX_BIT_WIDTH);
        end else begin
            eff_w = bit_width_reg;
        end
    end

    // varint: seven bits a byte, low group first
    assign hdr_shamt   = {shift_cnt_reg, 3'b000} - {3'b000, shift_cnt_reg};
    assign hdr_acc_new = hdr_acc_reg | (HDR_W'(b[6:0]) << hdr_shamt);
    assign hdr_count   = hdr_acc_new[HDR_W-1:1];

    assign val_acc_new = val_acc_reg | (32'(b) << {val_idx_reg, 3'b000});
    assign rle_nbytes  = 3'((gw_reg + WIDTH_W'(7)) >> 3);
    assign rle_done    = ({1'b0, val_idx_reg} + 3'd1) >= rle_nbytes;

    // packed: how many whole values the buffer holds after this byte
    assign bits_sum = bits_reg + 6'd8;
    assign buf_new  = bit_buf_reg | (BUF_W'(b) << bits_reg);

    always_comb begin
        k_fit = '0;
        for (int j = 0; j < 9; j++) begin
            prod[j] = KW_W'(j) * KW_W'(gw_reg);
        end
        for (int j = 1; j < 9; j++) begin
            if ({3'b000, bits_sum} >= prod[j]) begin
                k_fit = NRES_W'(j);
            end
        end
        k_cap = (pvl_reg < PVL_W'(8)) ? pvl_reg[NRES_W-1:0] : NRES_W'(8);
        k     = (k_fit < k_cap) ? k_fit : k_cap;
        kw    = prod[k];
    end

    assign buf_shift = buf_new >> kw;
    assign bits_rem  = bits_sum - kw[5:0];
    assign pvl_rem   = pvl_reg - PVL_W'(k);

    always_comb begin
        phase_next      = phase_reg;
        bytes_rem_next  = bytes_rem_reg;
        prefix_idx_next = prefix_idx_reg;
        hdr_acc_next    = hdr_acc_reg;
        shift_cnt_next  = shift_cnt_reg;
        run_count_next  = run_count_reg;
        val_acc_next    = val_acc_reg;
        val_idx_next    = val_idx_reg;
        bit_buf_next    = bit_buf_reg;
        bits_next       = bits_reg;
        pvl_next        = pvl_reg;
        counted_next    = counted_reg;
        gw_next         = gw_reg;
        data_seen       = 1'b0;
        err             = ERR_NONE;
        ent.word        = '0;
        ent.count       = '0;
        ent.n_results   = '0;
        ent.width       = gw_reg;

        ph = phase_reg;
        if (phase_reg == PH_START) begin
            ph = len_pref_reg ? PH_PREFIX : PH_HEADER;
        end
        phase_next = ph;

        case (ph)
            PH_PREFIX: begin
                bytes_rem_next = bytes_rem_reg | (32'(b) << {prefix_idx_reg, 3'b000});
                if (prefix_idx_reg == 2'd3) begin
                    prefix_idx_next = '0;
                    counted_next    = 1'b1;
                    phase_next      = (bytes_rem_next != '0) ? PH_HEADER : PH_DRAIN;
                end else begin
                    prefix_idx_next = prefix_idx_reg + 2'd1;
                end
            end
            PH_HEADER: begin
                data_seen    = 1'b1;
                hdr_acc_next = hdr_acc_new;
                if (b[7]) begin
                    if (shift_cnt_reg >= 3'd4) begin
                        err        = ERR_VARINT_LONG;
                        phase_next = PH_DRAIN;
                    end else begin
                        shift_cnt_next = shift_cnt_reg + 3'd1;
                    end
                end else begin
                    gw_next = eff_w;
                    if (hdr_acc_new[0]) begin
                        pvl_next     = {hdr_count, 3'b000};
                        bit_buf_next = '0;
                        bits_next    = '0;
                        phase_next   = (hdr_count != '0) ? PH_PACKED : PH_HEADER;
                    end else begin
                        run_count_next = (|hdr_count[HDR_W-2:32]) ? '1 : hdr_count[31:0];
                        val_acc_next   = '0;
                        val_idx_next   = '0;
                        phase_next     = PH_RLE;
                    end
                    hdr_acc_next   = '0;
                    shift_cnt_next = '0;
                end
            end
            PH_RLE: begin
                data_seen    = 1'b1;
                val_acc_next = val_acc_new;
                if (rle_done) begin
                    if (run_count_reg != '0) begin
                        ent.word      = QBUF_W'(val_acc_new);
                        ent.count     = run_count_reg;
                        ent.n_results = NRES_W'(1);
                    end
                    val_idx_next = '0;
                    phase_next   = PH_HEADER;
                end else begin
                    val_idx_next = val_idx_reg + 2'd1;
                end
            end
            PH_PACKED: begin
                data_seen     = 1'b1;
                ent.word      = QBUF_W'(buf_new);
                ent.count     = COUNT_W'(1);
                ent.n_results = k;
                pvl_next      = pvl_rem;
                if (pvl_rem == '0) begin
                    bit_buf_next = '0;
                    bits_next    = '0;
                    phase_next   = PH_HEADER;
                end else begin
                    bit_buf_next = buf_shift;
                    bits_next    = bits_rem;
                end
            end
            default: begin
            end
        endcase

        // counted stream: length runs out
        if (data_seen && counted_reg && bytes_rem_reg != '0) begin
            bytes_rem_next = bytes_rem_reg - 32'd1;
            if (bytes_rem_reg == 32'd1 && err == ERR_NONE) begin
                if (phase_next == PH_HEADER && shift_cnt_next == '0) begin
                    phase_next = PH_DRAIN;
                end else begin
                    err        = (phase_next == PH_HEADER) ? ERR_TRUNC_VARINT : ERR_TRUNC_RUN;
                    phase_next = PH_DRAIN;
                end
            end
        end

        if (s_data.final_byte) begin
            if (err == ERR_NONE) begin
                case (phase_next)
                    PH_PREFIX: err = ERR_TRUNC_RUN;
                    PH_HEADER: begin
                        if (shift_cnt_next != '0 || counted_next) begin
                            err = ERR_TRUNC_VARINT;
                        end
                    end
                    PH_RLE:    err = ERR_TRUNC_RUN;
                    PH_PACKED: err = ERR_TRUNC_RUN;
                    default: begin
                    end
                endcase
            end
            phase_next      = PH_START;
            bytes_rem_next  = '0;
            prefix_idx_next = '0;
            hdr_acc_next    = '0;
            shift_cnt_next  = '0;
            run_count_next  = '0;
            val_acc_next    = '0;
            val_idx_next    = '0;
            bit_buf_next    = '0;
            bits_next       = '0;
            pvl_next        = '0;
            counted_next    = 1'b0;
            gw_next         = WIDTH_W'(1);
        end

        if (err != ERR_NONE && ent.n_results == '0) begin
            ent.word      = '0;
            ent.count     = '0;
            ent.n_results = NRES_W'(1);
        end
        ent.err = err;
    end

    assign q_push  = accept && (ent.n_results != '0);
    assign q_wdata = ent;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_width_reg <= WIDTH_W'(1);
            len_pref_reg  <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_BIT_WIDTH:       bit_width_reg <= cfg_wdata[WIDTH_W-1:0];
                CFG_LENGTH_PREFIXED: len_pref_reg  <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_START;
            bytes_rem_reg  <= '0;
            prefix_idx_reg <= '0;
            hdr_acc_reg    <= '0;
            shift_cnt_reg  <= '0;
            run_count_reg  <= '0;
            val_acc_reg    <= '0;
            val_idx_reg    <= '0;
            bit_buf_reg    <= '0;
            bits_reg       <= '0;
            pvl_reg        <= '0;
            counted_reg    <= 1'b0;
            gw_reg         <= WIDTH_W'(1);
        end else if (accept) begin
            phase_reg      <= phase_next;
            bytes_rem_reg  <= bytes_rem_next;
            prefix_idx_reg <= prefix_idx_next;
            hdr_acc_reg    <= hdr_acc_next;
            shift_cnt_reg  <= shift_cnt_next;
            run_count_reg  <= run_count_next;
            val_acc_reg    <= val_acc_next;
            val_idx_reg    <= val_idx_next;
            bit_buf_reg    <= bit_buf_next;
            bits_reg       <= bits_next;
            pvl_reg        <= pvl_next;
            counted_reg    <= counted_next;
            gw_reg         <= gw_next;
        end
    end

endmodule

### rtl/core/rbh_back.sv
module rbh_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  rbh_pkg::q_entry_t  q_rdata,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output rbh_pkg::out_beat_t m_data
);
    import rbh_pkg::*;

    q_entry_t          cur_reg, cur_next;
    logic [NRES_W-1:0] left_reg, left_next;
    logic              valid_reg, valid_next;
    logic              last, take, load;

    assign last  = (left_reg == NRES_W'(1));
    assign take  = valid_reg && m_ready;
    assign load  = q_valid && (!valid_reg || (take && last));
    assign q_pop = load;

    always_comb begin
        cur_next   = cur_reg;
        left_next  = left_reg;
        valid_next = valid_reg;
        if (load) begin
            cur_next   = q_rdata;
            left_next  = q_rdata.n_results;
            valid_next = 1'b1;
        end else if (take) begin
            if (last) begin
                valid_next = 1'b0;
            end else begin
                // next packed value moves to the bottom
                cur_next.word = cur_reg.word >> cur_reg.width;
                left_next     = left_reg - NRES_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            left_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

    assign m_valid             = valid_reg;
    assign m_data.value        = cur_reg.word[VALUE_W-1:0] & width_mask(cur_reg.width);
    assign m_data.repeat_count = cur_reg.count;
    assign m_data.last_of_item = last;
    assign m_data.error_code   = last ? cur_reg.err : ERR_NONE;

endmodule

### rtl/core/rle_bitpacked_hybrid_decoder_unit.sv
// Decoder for the RLE / bit-packed hybrid run format, one encoded byte per beat
// on s_, decoded values on m_ with a repeat count (RLE runs are not expanded).
// Bytes are accepted at one per cycle while the queue is not full. A byte that
// completes k packed values (up to eight) gives k result beats, one value each;
// a four-entry queue between the byte parser and the result stage absorbs this,
// and s_ready drops while that queue is full. RLE values and error beats give a
// single result beat. The user must write bit_width and length_prefixed through
// the cfg_ port only while no stream is in flight; the block itself does not
// enforce this. The length flag is sampled at the first byte of each stream and
// the width at each run header. No clearing pass is needed after reset.
module rle_bitpacked_hybrid_decoder_unit #(
    parameter int MAX_BIT_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  rbh_pkg::in_beat_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output rbh_pkg::out_beat_t            m_data,
    input  logic                          cfg_we,
    input  logic [rbh_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [rbh_pkg::CFG_DAT_W-1:0] cfg_wdata
);
    import rbh_pkg::*;

    logic     q_push, q_full, q_valid, q_pop;
    q_entry_t q_wdata, q_rdata;

    rbh_front #(
        .MAX_BIT_WIDTH(MAX_BIT_WIDTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .q_push   (q_push),
        .q_wdata  (q_wdata),
        .q_full   (q_full)
    );

    rbh_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .rd_valid(q_valid),
        .rdata   (q_rdata),
        .pop     (q_pop)
    );

    rbh_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_rdata (q_rdata),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // an error code only rides on the closing beat of a byte
    a_err_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error_code != ERR_NONE |-> m_data.last_of_item)
        else $error("error code on a non-final beat");

    // only packed bytes give several beats, each with count one
    a_multi_is_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last_of_item |-> m_data.repeat_count == 32'd1)
        else $error("non-final beat with count other than one");

    // zero count only on a bare error beat
    a_zero_count_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.repeat_count == '0
            |-> m_data.error_code != ERR_NONE && m_data.value == '0)
        else $error("zero count beat without error");

endmodule
